// File: rtl/multichannel_pcm_mixer_core_defines.svh
// Assertion macros for the PCM mixer core.
// Included by the top level only; depends on nothing else.
`ifndef MULTICHANNEL_PCM_MIXER_CORE_DEFINES_SVH
`define MULTICHANNEL_PCM_MIXER_CORE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define PMX_ASSERT_IMPL(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define PMX_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);
`endif

// File: rtl/pmx_pkg.sv
// Shared types, constants and helpers for the PCM mixer core.
// No dependencies.
package pmx_pkg;
  localparam int NUM_CHANNELS = 8;
  localparam int STORE_DEPTH  = 4096;
  localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int CNT_W  = $clog2(NUM_CHANNELS + 1);
  localparam int VOL_MAX = 128;

  typedef enum logic [2:0] {
    OP_WRITE  = 3'd0,
    OP_PLAY   = 3'd1,
    OP_HALT   = 3'd2,
    OP_PAUSE  = 3'd3,
    OP_RESUME = 3'd4,
    OP_VOLUME = 3'd5,
    OP_MIX    = 3'd6,
    OP_NOP    = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MIX_RD,
    ST_MIX_ACC,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load;     // capture the accepted item
    logic             exec;     // execute a non-mix op
    logic             mix_seed; // seed the accumulator with the music sample
    logic             mix_rd;   // evaluate channel mix_ch and issue store read
    logic             mix_acc;  // add the fetched sample of channel mix_ch
    logic [CH_W-1:0]  mix_ch;
  } cmd_t;

  typedef struct packed {
    logic is_mix;
  } status_t;

  typedef struct packed {
    logic [2:0]   op;
    logic [2:0]   channel;
    logic         all_channels;
    logic [11:0]  address;
    logic [12:0]  length;
    logic [15:0]  loops;
    logic [8:0]   level;
    logic [15:0]  sample;
  } item_t;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    if (v > 18'sd32767) return 16'sh7fff;
    else if (v < -18'sd32768) return 16'sh8000;
    else return v[15:0];
  endfunction
endpackage

// File: rtl/pmx_ctrl.sv
// Controller state machine for the PCM mixer core.
// Depends on pmx_pkg.
module pmx_ctrl import pmx_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_fire,
  input  logic    out_free,
  input  status_t status,
  output logic    in_ready,
  output logic    out_load,
  output cmd_t    cmd
);
  state_t state_r, state_nxt;
  logic [CNT_W-1:0] ch_r, ch_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ch_r    <= '0;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    unique case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_EXEC;
      ST_EXEC: begin
        ch_nxt = '0;
        state_nxt = status.is_mix ? ST_MIX_RD : ST_OUT;
      end
      ST_MIX_RD: state_nxt = ST_MIX_ACC;
      ST_MIX_ACC: begin
        if (ch_r == CNT_W'(NUM_CHANNELS - 1)) state_nxt = ST_OUT;
        else begin
          ch_nxt = ch_r + CNT_W'(1);
          state_nxt = ST_MIX_RD;
        end
      end
      ST_OUT: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    out_load     = 1'b0;
    cmd          = '0;
    cmd.mix_ch   = ch_r[CH_W-1:0];
    unique case (state_r)
      ST_IDLE:    begin in_ready = 1'b1; cmd.load = in_fire; end
      ST_EXEC:    begin cmd.exec = !status.is_mix; cmd.mix_seed = status.is_mix; end
      ST_MIX_RD:  cmd.mix_rd = 1'b1;
      ST_MIX_ACC: cmd.mix_acc = 1'b1;
      ST_OUT:     out_load = out_free;
      default:    ;
    endcase
  end
endmodule

// File: rtl/pmx_datapath.sv
// Datapath of the PCM mixer core: channel registers, sample store, accumulator.
// Depends on pmx_pkg.
module pmx_datapath import pmx_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  item_t        in_item,
  input  cmd_t         cmd,
  output status_t      status,
  output logic [15:0]  mixed_sample,
  output logic [7:0]   finished_mask,
  output logic [7:0]   reply,
  output logic         failed
);
  item_t it_r;
  logic [15:0] store [STORE_DEPTH];
  logic [15:0] rd_r;

  logic [NUM_CHANNELS-1:0] act_r, pau_r;
  logic [ADDR_W-1:0] start_r [NUM_CHANNELS];
  logic [12:0] len_r [NUM_CHANNELS];
  logic [12:0] pos_r [NUM_CHANNELS];
  logic signed [15:0] rep_r [NUM_CHANNELS];
  logic [7:0] vol_r [NUM_CHANNELS];

  logic signed [15:0] acc_r;
  logic [7:0] fin_r, reply_r;
  logic fail_r, contrib_r;

  assign status.is_mix = (op_t'(it_r.op) == OP_MIX);
  assign mixed_sample  = acc_r;
  assign finished_mask = fin_r;
  assign reply         = reply_r;
  assign failed        = fail_r;

  // Lowest free channel.
  logic free_found;
  logic [CH_W-1:0] free_ch;
  always_comb begin
    free_found = 1'b0;
    free_ch = '0;
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (!act_r[i]) begin
        free_found = 1'b1;
        free_ch = CH_W'(i);
      end
    end
  end

  logic ch_ok;
  logic [CH_W-1:0] ch_sel;
  assign ch_ok  = ({1'b0, it_r.channel} < 4'(NUM_CHANNELS));
  assign ch_sel = it_r.channel[CH_W-1:0];

  logic signed [9:0] lvl_c;
  assign lvl_c = ($signed(it_r.level) > 9'sd128) ? 10'sd128 : 10'($signed(it_r.level));

  // Mix evaluation for the channel under service.
  logic [CH_W-1:0] mc;
  logic m_run, m_wrap, m_fin;
  logic [12:0] m_pos;
  assign mc     = cmd.mix_ch;
  assign m_run  = act_r[mc] && !pau_r[mc];
  assign m_wrap = (pos_r[mc] >= len_r[mc]);
  assign m_fin  = m_wrap && ((rep_r[mc] == 16'sd0) || (len_r[mc] == 13'd0));
  assign m_pos  = m_wrap ? 13'd0 : pos_r[mc];

  logic [ADDR_W-1:0] rd_addr;
  assign rd_addr = start_r[mc] + m_pos[ADDR_W-1:0];

  // Scaled contribution: product, then truncation toward zero by 128.
  logic signed [24:0] prod;
  logic signed [17:0] scaled;
  assign prod   = $signed(rd_r) * $signed({1'b0, vol_r[mc]});
  assign scaled = 18'(($signed(prod) + ((prod < 0) ? 25'sd127 : 25'sd0)) >>> 7);

  always_ff @(posedge clk) begin
    if (cmd.load) it_r <= in_item;
    if (cmd.exec && op_t'(it_r.op) == OP_WRITE) store[it_r.address[ADDR_W-1:0]] <= it_r.sample;
    if (cmd.mix_rd) rd_r <= store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= '0;
      pau_r <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        start_r[i] <= '0; len_r[i] <= '0; pos_r[i] <= '0;
        rep_r[i] <= '0; vol_r[i] <= 8'(VOL_MAX);
      end
      acc_r <= '0; fin_r <= '0; reply_r <= '0; fail_r <= 1'b0; contrib_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        acc_r <= '0; fin_r <= '0; reply_r <= '0; fail_r <= 1'b0;
      end
      if (cmd.exec) begin
        unique case (op_t'(it_r.op))
          OP_PLAY: begin
            if ((it_r.all_channels && free_found) || (!it_r.all_channels && ch_ok)) begin
              automatic logic [CH_W-1:0] t = it_r.all_channels ? free_ch : ch_sel;
              act_r[t] <= 1'b1; pau_r[t] <= 1'b0;
              start_r[t] <= it_r.address[ADDR_W-1:0];
              len_r[t] <= it_r.length; pos_r[t] <= '0;
              rep_r[t] <= $signed(it_r.loops);
              reply_r <= 8'(t);
            end else fail_r <= 1'b1;
          end
          OP_HALT, OP_PAUSE, OP_RESUME: begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
              if (it_r.all_channels || ({1'b0, it_r.channel} == 4'(i))) begin
                if (op_t'(it_r.op) == OP_HALT) act_r[i] <= 1'b0;
                else pau_r[i] <= (op_t'(it_r.op) == OP_PAUSE);
              end
            end
          end
          OP_VOLUME: begin
            if (it_r.all_channels) begin
              reply_r <= vol_r[0];
              if (lvl_c >= 0) for (int i = 0; i < NUM_CHANNELS; i++) vol_r[i] <= 8'(lvl_c);
            end else if (ch_ok) begin
              reply_r <= vol_r[ch_sel];
              if (lvl_c >= 0) vol_r[ch_sel] <= 8'(lvl_c);
            end
          end
          default: ;
        endcase
      end
      if (cmd.mix_seed) acc_r <= it_r.sample;
      if (cmd.mix_rd) begin
        contrib_r <= m_run && !m_fin;
        if (m_run) begin
          if (m_fin) begin
            act_r[mc] <= 1'b0;
            if (32'(mc) < 8) fin_r[3'(mc)] <= 1'b1;
          end else begin
            if (m_wrap && rep_r[mc] > 0) rep_r[mc] <= rep_r[mc] - 16'sd1;
            pos_r[mc] <= m_pos + 13'd1;
          end
        end
      end
      if (cmd.mix_acc && contrib_r) acc_r <= sat16(18'(acc_r) + scaled);
    end
  end
endmodule

// File: rtl/multichannel_pcm_mixer_core.sv
// Top level of the multichannel PCM mixer core.
// Depends on pmx_pkg, pmx_ctrl, pmx_datapath and the defines header.
//
// Channel  Direction  tdata fields (low bit up)                         tuser
// in_      slave      op, channel, all_channels, address, length,       -
//                     loops, level, sample (73 bits in 80)
// out_     master     mixed_sample, finished_mask, reply, failed (33 in 40) -
//
// A mix item seeds the accumulator, then does one store read and one accumulate per
// channel, in channel order, before the output state. Other ops skip the channel steps.
// Reset is synchronous, active low; channel state resets, the store does not.
// A stalled output holds the result and the next item waits in the input.
`include "multichannel_pcm_mixer_core_defines.svh"
module multichannel_pcm_mixer_core import pmx_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,  // op, channel, all_channels, address, length, loops, level, sample
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata  // mixed_sample, finished_mask, reply, failed
);
  item_t item;
  cmd_t cmd;
  status_t status;
  logic in_fire, out_free, out_load;
  logic [15:0] mixed;
  logic [7:0] fin, rep;
  logic fail;
  logic out_valid_r;
  logic [32:0] out_data_r;

  assign item.op           = in_tdata[2:0];
  assign item.channel      = in_tdata[5:3];
  assign item.all_channels = in_tdata[6];
  assign item.address      = in_tdata[18:7];
  assign item.length       = in_tdata[31:19];
  assign item.loops        = in_tdata[47:32];
  assign item.level        = in_tdata[56:48];
  assign item.sample       = in_tdata[72:57];

  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  pmx_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_free(out_free),
    .status(status), .in_ready(in_tready), .out_load(out_load), .cmd(cmd)
  );

  pmx_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .in_item(item), .cmd(cmd), .status(status),
    .mixed_sample(mixed), .finished_mask(fin), .reply(rep), .failed(fail)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (out_load) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
    if (out_load) out_data_r <= {fail, rep, fin, mixed};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_data_r};

  `PMX_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, cmd.mix_rd || cmd.mix_acc, !in_tready, "input accepted during mix")
  `PMX_ASSERT_NEXT(a_load_valid, clk, rst_n, out_load, out_tvalid, "result not presented after load")
  `PMX_ASSERT_IMPL(a_load_free, clk, rst_n, out_load, out_free, "result overwritten while pending")
endmodule

// File: sim/multichannel_pcm_mixer_core_test.sv
// Testbench for the multichannel PCM mixer core: streams mixer commands through
// the input channel and checks each result against a behavioral mixer model.
// Depends on pmx_pkg and the multichannel_pcm_mixer_core RTL.
`timescale 1ns / 1ps

class mixer_scoreboard;
  logic [15:0] store [0:4095];
  bit          act [8];
  bit          pau [8];
  logic [11:0] start [8];
  int          len [8];
  int          pos [8];
  int          reps [8];
  int          vol [8];
  logic [39:0] pending [$];
  int          errors;
  int          n_mix, n_fin, n_fail;

  function void clear();
    for (int i = 0; i < 8; i++) begin
      act[i] = 0; pau[i] = 0; start[i] = 0; len[i] = 0; pos[i] = 0; reps[i] = 0;
      vol[i] = 128;
    end
    pending.delete();
    errors = 0;
  endfunction

  // Models one accepted command and queues the result it produces.
  function void note_command(pmx_pkg::item_t it);
    int mixed, lvl, target, s;
    logic [7:0] fin, reply;
    bit fail;
    mixed = 0; fin = 0; reply = 0; fail = 0;
    lvl = $signed(it.level);
    case (pmx_pkg::op_t'(it.op))
      pmx_pkg::OP_WRITE: begin
        store[it.address] = it.sample;
      end
      pmx_pkg::OP_PLAY: begin
        target = -1;
        if (it.all_channels) begin
          for (int i = 7; i >= 0; i--) if (!act[i]) target = i;
        end else target = it.channel;
        if (target < 0) fail = 1;
        else begin
          act[target] = 1; pau[target] = 0; start[target] = it.address;
          len[target] = it.length; pos[target] = 0;
          reps[target] = $signed(it.loops); reply = target;
        end
      end
      pmx_pkg::OP_HALT, pmx_pkg::OP_PAUSE, pmx_pkg::OP_RESUME: begin
        for (int i = 0; i < 8; i++) begin
          if (it.all_channels || i == it.channel) begin
            if (it.op == pmx_pkg::OP_HALT) act[i] = 0;
            else pau[i] = (it.op == pmx_pkg::OP_PAUSE);
          end
        end
      end
      pmx_pkg::OP_VOLUME: begin
        if (lvl > 128) lvl = 128;
        if (it.all_channels) begin
          reply = vol[0];
          if (lvl >= 0) for (int i = 0; i < 8; i++) vol[i] = lvl;
        end else begin
          reply = vol[it.channel];
          if (lvl >= 0) vol[it.channel] = lvl;
        end
      end
      pmx_pkg::OP_MIX: begin
        n_mix++;
        mixed = $signed(it.sample);
        for (int i = 0; i < 8; i++) begin
          if (!act[i] || pau[i]) continue;
          if (pos[i] >= len[i]) begin
            if (reps[i] == 0 || len[i] == 0) begin
              act[i] = 0; fin[i] = 1;
              continue;
            end
            if (reps[i] > 0) reps[i]--;
            pos[i] = 0;
          end
          s = $signed(store[(start[i] + pos[i]) % 4096]);
          mixed = mixed + (s * vol[i]) / 128;
          if (mixed > 32767) mixed = 32767;
          if (mixed < -32768) mixed = -32768;
          pos[i]++;
        end
        if (fin != 0) n_fin++;
      end
      default: ;
    endcase
    if (fail) n_fail++;
    pending.push_back({7'd0, fail, reply, fin, mixed[15:0]});
  endfunction

  function void check_result(logic [39:0] got);
    logic [39:0] exp;
    if (pending.size() == 0) begin
      $error("result with no command outstanding: %h", got);
      errors++;
      return;
    end
    exp = pending.pop_front();
    if (got[15:0] !== exp[15:0]) begin
      $error("mixed_sample expected %0d got %0d", $signed(exp[15:0]), $signed(got[15:0]));
      errors++;
    end
    if (got[23:16] !== exp[23:16]) begin
      $error("finished_mask expected %h got %h", exp[23:16], got[23:16]);
      errors++;
    end
    if (got[31:24] !== exp[31:24]) begin
      $error("reply expected %0d got %0d", exp[31:24], got[31:24]);
      errors++;
    end
    if (got[32] !== exp[32]) begin
      $error("failed expected %b got %b", exp[32], got[32]);
      errors++;
    end
  endfunction
endclass

module multichannel_pcm_mixer_core_test;
  import pmx_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [79:0] in_tdata;  // op, channel, all_channels, address, length, loops, level, sample
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata; // mixed_sample, finished_mask, reply, failed

  mixer_scoreboard mixer_model;
  int send_idle_pct, recv_idle_pct;
  int cycle_count;

  multichannel_pcm_mixer_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 600000) begin
      $display("** multichannel_pcm_mixer_core: FAILED **");
      $finish;
    end
  end

  // Receiver: random stall, check each transfer.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) mixer_model.check_result(out_tdata);
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Valid stays high after a transfer until the next idle cycle or drain.
  task automatic send(item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata  <= {7'd0, it.sample, it.level, it.loops, it.length, it.address,
                  it.all_channels, it.channel, it.op};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    mixer_model.note_command(it);
  endtask

  function automatic item_t make_cmd(op_t op, int ch, bit all, int addr, int len,
                                     int loops, int lvl, int smp);
    item_t it;
    it.op = op; it.channel = 3'(ch); it.all_channels = all; it.address = 12'(addr);
    it.length = 13'(len); it.loops = 16'(loops); it.level = 9'(lvl); it.sample = 16'(smp);
    return it;
  endfunction

  // Chunks stay inside the written region 0..255 so no unwritten word is read.
  function automatic item_t random_cmd();
    int r, a, l, m;
    r = $urandom_range(99);
    a = $urandom_range(255);
    m = 256 - a;
    l = $urandom_range(0, m);
    if (r < 8) return make_cmd(OP_WRITE, 0, 0, $urandom_range(255), 0, 0, 0, $urandom);
    if (r < 20) return make_cmd(OP_PLAY, $urandom_range(7), $urandom_range(1), a,
                                ($urandom_range(9) == 0) ? l :
                                $urandom_range(0, (m < 6) ? m : 6),
                                ($urandom_range(3) == 0) ? -1 : $urandom_range(0, 3),
                                $urandom, $urandom);
    if (r < 24) return make_cmd(OP_HALT, $urandom_range(7), $urandom_range(5) == 0,
                                $urandom, $urandom, $urandom, $urandom, $urandom);
    if (r < 28) return make_cmd(OP_PAUSE, $urandom_range(7), $urandom_range(5) == 0,
                                $urandom, $urandom, $urandom, $urandom, $urandom);
    if (r < 32) return make_cmd(OP_RESUME, $urandom_range(7), $urandom_range(3) == 0,
                                $urandom, $urandom, $urandom, $urandom, $urandom);
    if (r < 38) return make_cmd(OP_VOLUME, $urandom_range(7), $urandom_range(1), $urandom,
                                $urandom, $urandom, $urandom_range(0, 256) - 1, $urandom);
    if (r < 40) return make_cmd(OP_NOP, $urandom, $urandom, $urandom, $urandom,
                                $urandom, $urandom, $urandom);
    return make_cmd(OP_MIX, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom);
  endfunction

  task automatic drain();
    in_tvalid <= 1'b0;
    while (mixer_model.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    mixer_model = new();
    mixer_model.clear();
    rst_n = 0; in_tvalid = 0; in_tdata = '0; out_tready = 0; cycle_count = 0;
    send_idle_pct = 0; recv_idle_pct = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: fill the low store with extremes and an XOR-scrambled ramp.
    for (int a = 0; a < 256; a++)
      mixer_model.store[a] = 0;
    send(make_cmd(OP_WRITE, 0, 0, 0, 0, 0, 0, 16'h7fff));
    send(make_cmd(OP_WRITE, 0, 0, 1, 0, 0, 0, 16'h8000));
    send(make_cmd(OP_WRITE, 0, 0, 4095, 0, 0, 0, 16'h1234));
    for (int a = 2; a < 256; a++)
      send(make_cmd(OP_WRITE, 0, 0, a, 0, 0, 0, (a * 517) ^ 16'ha5a5));
    send(make_cmd(OP_VOLUME, 0, 1, 0, 0, 0, -1, 0));           // query only
    send(make_cmd(OP_VOLUME, 3, 0, 0, 0, 0, 255, 0));          // clamps to 128
    send(make_cmd(OP_PAUSE, 5, 0, 0, 0, 0, 0, 0));             // pause an idle channel
    for (int i = 0; i < 8; i++)
      send(make_cmd(OP_PLAY, 0, 1, 0, 2, (i == 0) ? -1 : 32767, 0, 0));
    send(make_cmd(OP_PLAY, 0, 1, 0, 2, 0, 0, 0));              // none free
    send(make_cmd(OP_MIX, 0, 0, 0, 0, 0, 0, 16'h7fff));        // saturate high
    send(make_cmd(OP_PLAY, 2, 0, 4095, 2, 0, 0, 0));           // wraps, busy channel
    send(make_cmd(OP_PLAY, 4, 0, 1, 0, 0, 0, 0));              // zero length
    send(make_cmd(OP_MIX, 0, 0, 0, 0, 0, 0, 16'h8000));
    send(make_cmd(OP_MIX, 0, 0, 0, 0, 0, 0, 0));
    send(make_cmd(OP_MIX, 0, 0, 0, 0, 0, 0, 0));
    send(make_cmd(OP_VOLUME, 0, 1, 0, 0, 0, 0, 0));
    send(make_cmd(OP_RESUME, 0, 1, 0, 0, 0, 0, 0));
    send(make_cmd(OP_HALT, 0, 1, 0, 0, 0, 0, 0));
    send(make_cmd(OP_NOP, 7, 1, 4095, 8191, -1, -1, -1));
    send(make_cmd(OP_PLAY, 1, 0, 0, 4096, -1, 0, 0));          // long chunk, bounded read
    send(make_cmd(OP_HALT, 1, 0, 0, 0, 0, 0, 0));
    send(make_cmd(OP_VOLUME, 0, 1, 0, 0, 0, 100, 0));
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 86 : 0;
      recv_idle_pct = (phase == 0) ? 86 : (phase == 1) ? 26 : 0;
      for (int n = 0; n < 156; n++) begin
        send(random_cmd());
        if (phase == 2 && n == 60) drain();   // hold off until all results are back
      end
    end

    drain();
    repeat (40) @(posedge clk);
    $display("Covered %0d mix slots, %0d with finished channels, %0d failed plays.",
             mixer_model.n_mix, mixer_model.n_fin, mixer_model.n_fail);
    if (mixer_model.errors == 0 && mixer_model.pending.size() == 0)
      $display("** multichannel_pcm_mixer_core: PASSED **");
    else
      $display("** multichannel_pcm_mixer_core: FAILED **");
    $finish;
  end
endmodule

// File: multichannel_pcm_mixer_core.f
+incdir+rtl
rtl/pmx_pkg.sv
rtl/pmx_ctrl.sv
rtl/pmx_datapath.sv
rtl/multichannel_pcm_mixer_core.sv
sim/multichannel_pcm_mixer_core_test.sv
